@@ rtl/scpct_pkg.sv @@
// Shared constants and types of the second-chance page cache tag manager.
`default_nettype none
package scpct_pkg;

	localparam int NUM_LINES = 16;
	localparam int PAGE_BITS = 20;
	localparam int LINE_W    = $clog2(NUM_LINES);
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;

	localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(NUM_LINES - 1);

	localparam int S_TDATA_W  = ((PAGE_BITS + 7) / 8) * 8;
	localparam int M_FIELDS_W = LINE_W + 1 + PAGE_BITS + 1;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FREE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FLUSH = 3'd4;

	typedef struct packed {
		logic                 re;
		logic                 we;
		logic [LINE_W-1:0]    addr;
		logic [PAGE_BITS-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic                 vld;
		logic [STATUS_W-1:0]  status;
		logic [LINE_W-1:0]    line;
		logic                 ev_valid;
		logic [PAGE_BITS-1:0] ev_page;
		logic                 wb;
		logic                 last;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/scpct_ram.sv @@
// Generic single-port synchronous RAM with registered read.
`default_nettype none
module scpct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/scpct_ctrl.sv @@
// Sequencer: range check, tag scan, free-line fill, clock sweep, flush, line status bits.
`default_nettype none
module scpct_ctrl import scpct_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [PAGE_BITS-1:0] cfg_wdata,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [CMD_W-1:0]     in_cmd,
	input  wire logic [PAGE_BITS-1:0] in_page,
	input  wire logic                 out_free,
	output ram_req_t                  ram_req,
	input  wire logic [PAGE_BITS-1:0] ram_rdata,
	output result_t                   res
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1;
	localparam logic [3:0] S_HIT   = 4'd2;
	localparam logic [3:0] S_MISS  = 4'd3;
	localparam logic [3:0] S_SWEEP = 4'd4;
	localparam logic [3:0] S_EVICT = 4'd5;
	localparam logic [3:0] S_RANGE = 4'd6;
	localparam logic [3:0] S_FL_RD = 4'd7;
	localparam logic [3:0] S_FL_EM = 4'd8;

	logic [3:0]           state_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [PAGE_BITS-1:0] max_page_q;
	logic [LINE_W-1:0]    rd_cnt_q;
	logic                 cmp_vld_s1;
	logic [LINE_W-1:0]    cmp_idx_s1;
	logic                 free_found_q;
	logic [LINE_W-1:0]    free_idx_q;
	logic [LINE_W-1:0]    hit_idx_q;
	logic [LINE_W-1:0]    hand_q;
	logic [NUM_LINES-1:0] valid_q;
	logic [NUM_LINES-1:0] ref_q;
	logic [NUM_LINES-1:0] dirty_q;

	logic              hit_now;
	logic              scan_end;
	logic [LINE_W-1:0] hand_nx;
	logic [LINE_W-1:0] rd_cnt_nx;

	assign in_ready  = (state_q == S_IDLE);
	assign hit_now   = (state_q == S_SCAN) && cmp_vld_s1 && valid_q[cmp_idx_s1]
	                   && (ram_rdata == page_q);
	assign scan_end  = (state_q == S_SCAN) && cmp_vld_s1 && (cmp_idx_s1 == LAST_LINE)
	                   && !hit_now;
	assign hand_nx   = (hand_q == LAST_LINE) ? '0 : hand_q + 1'b1;
	assign rd_cnt_nx = (rd_cnt_q == LAST_LINE) ? '0 : rd_cnt_q + 1'b1;

	always_comb begin
		ram_req = '0;
		res     = '0;
		unique case (state_q)
			S_SCAN: begin
				ram_req.re   = 1'b1;
				ram_req.addr = rd_cnt_q;
			end
			S_HIT: begin
				res.vld    = out_free;
				res.status = ST_HIT;
				res.line   = hit_idx_q;
				res.last   = 1'b1;
			end
			S_MISS: begin
				if (free_found_q && out_free) begin
					ram_req.we    = 1'b1;
					ram_req.addr  = free_idx_q;
					ram_req.wdata = page_q;
					res.vld       = 1'b1;
					res.status    = ST_FREE;
					res.line      = free_idx_q;
					res.last      = 1'b1;
				end
			end
			S_SWEEP: begin
				// victim found: fetch its tag for the eviction report
				if (!ref_q[hand_nx]) begin
					ram_req.re   = 1'b1;
					ram_req.addr = hand_nx;
				end
			end
			S_EVICT: begin
				if (out_free) begin
					ram_req.we    = 1'b1;
					ram_req.addr  = hand_q;
					ram_req.wdata = page_q;
					res.vld       = 1'b1;
					res.status    = ST_EVICT;
					res.line      = hand_q;
					res.ev_valid  = 1'b1;
					res.ev_page   = ram_rdata;
					res.wb        = dirty_q[hand_q];
					res.last      = 1'b1;
				end
			end
			S_RANGE: begin
				res.vld    = out_free;
				res.status = ST_RANGE;
				res.last   = 1'b1;
			end
			S_FL_RD: begin
				ram_req.re   = 1'b1;
				ram_req.addr = rd_cnt_q;
			end
			S_FL_EM: begin
				res.vld      = out_free;
				res.status   = ST_FLUSH;
				res.line     = rd_cnt_q;
				res.ev_valid = valid_q[rd_cnt_q];
				res.ev_page  = valid_q[rd_cnt_q] ? ram_rdata : '0;
				res.wb       = valid_q[rd_cnt_q] & dirty_q[rd_cnt_q];
				res.last     = (rd_cnt_q == LAST_LINE);
			end
			default: begin
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_cnt_q;
		if (state_q == S_IDLE && in_valid) begin
			cmd_q  <= in_cmd;
			page_q <= in_page;
		end
		if (hit_now) begin
			hit_idx_q <= cmp_idx_s1;
		end
		if (state_q == S_SCAN && cmp_vld_s1 && !valid_q[cmp_idx_s1] && !free_found_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_page_q   <= '1;
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
			hand_q       <= LAST_LINE;
			valid_q      <= '0;
			ref_q        <= '0;
			dirty_q      <= '0;
		end else begin
			if (cfg_we) begin
				max_page_q <= cfg_wdata;
			end
			cmp_vld_s1 <= (state_q == S_SCAN) && !hit_now && !scan_end;
			unique case (state_q)
				S_IDLE: begin
					rd_cnt_q     <= '0;
					free_found_q <= 1'b0;
					if (in_valid) begin
						unique case (in_cmd)
							CMD_FLUSH: state_q <= S_FL_RD;
							CMD_NONE:  state_q <= S_IDLE;
							default: begin
								state_q <= (in_page > max_page_q) ? S_RANGE : S_SCAN;
							end
						endcase
					end
				end
				S_SCAN: begin
					rd_cnt_q <= rd_cnt_nx;
					if (cmp_vld_s1 && !valid_q[cmp_idx_s1]) begin
						free_found_q <= 1'b1;
					end
					if (hit_now) begin
						state_q <= S_HIT;
					end else if (scan_end) begin
						state_q <= S_MISS;
					end
				end
				S_HIT: begin
					if (out_free) begin
						ref_q[hit_idx_q] <= 1'b1;
						if (cmd_q == CMD_WRITE) begin
							dirty_q[hit_idx_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_MISS: begin
					if (!free_found_q) begin
						state_q <= S_SWEEP;
					end else if (out_free) begin
						valid_q[free_idx_q] <= 1'b1;
						ref_q[free_idx_q]   <= 1'b1;
						dirty_q[free_idx_q] <= (cmd_q == CMD_WRITE);
						state_q             <= S_IDLE;
					end
				end
				S_SWEEP: begin
					hand_q <= hand_nx;
					if (ref_q[hand_nx]) begin
						ref_q[hand_nx] <= 1'b0;
					end else begin
						state_q <= S_EVICT;
					end
				end
				S_EVICT: begin
					if (out_free) begin
						valid_q[hand_q] <= 1'b1;
						ref_q[hand_q]   <= 1'b1;
						dirty_q[hand_q] <= (cmd_q == CMD_WRITE);
						state_q         <= S_IDLE;
					end
				end
				S_RANGE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FL_RD: begin
					state_q <= S_FL_EM;
				end
				S_FL_EM: begin
					if (out_free) begin
						valid_q[rd_cnt_q] <= 1'b0;
						ref_q[rd_cnt_q]   <= 1'b0;
						dirty_q[rd_cnt_q] <= 1'b0;
						rd_cnt_q          <= rd_cnt_nx;
						state_q           <= (rd_cnt_q == LAST_LINE) ? S_IDLE : S_FL_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_res_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.vld |-> out_free)
		else $error("result word issued while output register busy");

	a_sweep_all_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> (&valid_q))
		else $error("clock sweep started with a free line present");

	a_victim_unref: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT) |-> !ref_q[hand_q])
		else $error("victim line still referenced");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FL_EM && out_free && rd_cnt_q == LAST_LINE)
		|=> (valid_q == '0 && ref_q == '0 && dirty_q == '0))
		else $error("lines left valid after flush");

endmodule
`default_nettype wire

@@ rtl/scpct_out.sv @@
// Output register of the result stream.
`default_nettype none
module scpct_out import scpct_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  result_t                   res,
	output logic                      out_free,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0]      m_axis_tdata,
	output logic [STATUS_W-1:0]       m_axis_tuser,
	output logic                      m_axis_tlast
);

	logic                  vld_q;
	logic [STATUS_W-1:0]   status_q;
	logic [M_FIELDS_W-1:0] fields_q;
	logic                  last_q;

	assign out_free      = !vld_q || m_axis_tready;
	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = M_TDATA_W'(fields_q);
	assign m_axis_tuser  = status_q;
	assign m_axis_tlast  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (res.vld) begin
			vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.vld) begin
			status_q <= res.status;
			fields_q <= {res.wb, res.ev_page, res.ev_valid, res.line};
			last_q   <= res.last;
		end
	end

endmodule
`default_nettype wire

@@ rtl/second_chance_page_cache_tags_top.sv @@
// Top level of the second-chance page cache tag manager.
// Tags of a fully associative page cache of NUM_LINES lines with clock replacement. A read
// or write takes one word on the slave side and gives one result word; a flush gives one
// word per line, line 0 first, tlast on the final one. Items are handled one at a time.
// The tags sit in a single-port RAM that is scanned one line per cycle, ending early when a
// line hits. On a miss with every line valid, the clock hand then sweeps reference bits to
// find a victim. Out-of-range requests skip the scan, and a flush does one RAM read per
// reported line. Valid, referenced and dirty bits are flip-flops cleared by reset, so no
// clearing pass is needed. A result waiting in the output register stalls the sequencer
// only when the next result is due.
`default_nettype none
module second_chance_page_cache_tags_top import scpct_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [PAGE_BITS-1:0] cfg_wdata,     // max_page
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // page_number
	input  wire logic [CMD_W-1:0]     s_axis_tuser,  // cmd
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// line_index, evicted_valid, evicted_page, needs_writeback
	output logic [M_TDATA_W-1:0]      m_axis_tdata,
	output logic [STATUS_W-1:0]       m_axis_tuser,  // status
	output logic                      m_axis_tlast
);

	ram_req_t             ram_req;
	logic [PAGE_BITS-1:0] ram_rdata;
	result_t              res;
	logic                 out_free;

	scpct_ram #(
		.WIDTH(PAGE_BITS),
		.DEPTH(NUM_LINES)
	) u_tags (
		.clk  (clk),
		.we   (ram_req.we),
		.re   (ram_req.re),
		.addr (ram_req.addr),
		.wdata(ram_req.wdata),
		.rdata(ram_rdata)
	);

	scpct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_page  (s_axis_tdata[PAGE_BITS-1:0]),
		.out_free (out_free),
		.ram_req  (ram_req),
		.ram_rdata(ram_rdata),
		.res      (res)
	);

	scpct_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.out_free     (out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
`default_nettype wire

@@ tb/tb_second_chance_page_cache_tags_top.sv @@
// Self-checking testbench of the second-chance page cache tag manager.
module tb_second_chance_page_cache_tags_top;
	import scpct_pkg::*;

	localparam int HOT_PAGES  = 24;
	localparam int IDLE_TAIL  = 2 * NUM_LINES + 8;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [LINE_W-1:0]    line;
		logic                 ev_valid;
		logic [PAGE_BITS-1:0] ev_page;
		logic                 wb;
		logic                 last;
	} tag_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [PAGE_BITS-1:0] cfg_wdata = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // page_number
	logic [CMD_W-1:0]     s_axis_tuser = CMD_READ; // cmd
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;  // line_index, evicted_valid, evicted_page, needs_writeback
	logic [STATUS_W-1:0]  m_axis_tuser;  // status
	logic                 m_axis_tlast;

	// Tag state as the block should hold it
	logic [PAGE_BITS-1:0] tag_q [NUM_LINES];
	logic                 valid_q [NUM_LINES];
	logic                 referenced_q [NUM_LINES];
	logic                 dirty_q [NUM_LINES];
	logic [LINE_W-1:0]    hand_q = LAST_LINE;
	logic [PAGE_BITS-1:0] page_limit = '1;

	tag_result_t          expected_words [$];
	logic [PAGE_BITS-1:0] hot_pages [HOT_PAGES];

	int fail_count     = 0;
	int requests_sent  = 0;
	int flushes_sent   = 0;
	int evictions_due  = 0;
	int words_checked  = 0;
	int burst_left     = 0;
	int hold_cycles    = 0;
	int stall_mode     = 0;
	int mode_left      = 0;

	second_chance_page_cache_tags_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < NUM_LINES; i++) begin
			tag_q[i]        = '0;
			valid_q[i]      = 1'b0;
			referenced_q[i] = 1'b0;
			dirty_q[i]      = 1'b0;
		end
	end

	// Applies one accepted request to the tag state and queues the words it must produce
	task automatic predict_page_access(input logic [CMD_W-1:0] cmd,
			input logic [PAGE_BITS-1:0] page);
		int          i;
		int          slot;
		tag_result_t r;
		slot = -1;
		r = '0;
		r.last = 1'b1;
		if (cmd == CMD_NONE)
			return;
		requests_sent++;
		if (cmd == CMD_FLUSH) begin
			flushes_sent++;
			for (i = 0; i < NUM_LINES; i++) begin
				r.status   = ST_FLUSH;
				r.line     = LINE_W'(i);
				r.ev_valid = valid_q[i];
				r.ev_page  = valid_q[i] ? tag_q[i] : '0;
				r.wb       = valid_q[i] && dirty_q[i];
				r.last     = (i == NUM_LINES - 1);
				expected_words.push_back(r);
				valid_q[i]      = 1'b0;
				referenced_q[i] = 1'b0;
				dirty_q[i]      = 1'b0;
			end
			return;
		end
		if (page > page_limit) begin
			r.status = ST_RANGE;
			expected_words.push_back(r);
			return;
		end
		for (i = 0; i < NUM_LINES; i++)
			if (slot < 0 && valid_q[i] && tag_q[i] == page)
				slot = i;
		if (slot >= 0) begin
			referenced_q[slot] = 1'b1;
			if (cmd == CMD_WRITE)
				dirty_q[slot] = 1'b1;
			r.status = ST_HIT;
			r.line   = LINE_W'(slot);
			expected_words.push_back(r);
			return;
		end
		for (i = 0; i < NUM_LINES; i++)
			if (slot < 0 && !valid_q[i])
				slot = i;
		if (slot >= 0) begin
			r.status = ST_FREE;
		end else begin
			// every line is valid: sweep the hand, giving referenced lines a second chance
			hand_q = LINE_W'((hand_q + 1) % NUM_LINES);
			while (referenced_q[hand_q]) begin
				referenced_q[hand_q] = 1'b0;
				hand_q = LINE_W'((hand_q + 1) % NUM_LINES);
			end
			slot = hand_q;
			evictions_due++;
			r.status   = ST_EVICT;
			r.ev_valid = 1'b1;
			r.ev_page  = tag_q[slot];
			r.wb       = dirty_q[slot];
		end
		r.line = LINE_W'(slot);
		expected_words.push_back(r);
		tag_q[slot]        = page;
		valid_q[slot]      = 1'b1;
		referenced_q[slot] = 1'b1;
		dirty_q[slot]      = (cmd == CMD_WRITE);
	endtask

	// Offers one request word, with random gaps between bursts
	task automatic offer_request(input logic [CMD_W-1:0] cmd, input logic [PAGE_BITS-1:0] page);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_TDATA_W'(page);
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predict_page_access(cmd, page);
	endtask

	// Sender stops until every expected word is back and the block has settled
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic write_page_limit(input logic [PAGE_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we     <= 1'b0;
		page_limit = value;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Receiver: long hold-offs on request, otherwise changing stall patterns
	always @(posedge clk) begin
		if (hold_cycles != 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles   <= hold_cycles - 1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(5, 60);
			end
			mode_left--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		tag_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected: status %0d tdata 0x%0h",
					m_axis_tuser, m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				compare_field("status", 32'(want.status), 32'(m_axis_tuser));
				compare_field("line_index", 32'(want.line),
					32'(m_axis_tdata[LINE_W-1:0]));
				compare_field("evicted_valid", 32'(want.ev_valid),
					32'(m_axis_tdata[LINE_W]));
				compare_field("evicted_page", 32'(want.ev_page),
					32'(m_axis_tdata[LINE_W+PAGE_BITS:LINE_W+1]));
				compare_field("needs_writeback", 32'(want.wb),
					32'(m_axis_tdata[LINE_W+PAGE_BITS+1]));
				compare_field("last", 32'(want.last), 32'(m_axis_tlast));
			end
		end
	end

	// Free fills at both ends of the page range, hits, dirtying, flush and the unused command
	task automatic test_basic_access();
		offer_request(CMD_READ, '0);
		offer_request(CMD_WRITE, '1);
		offer_request(CMD_READ, '0);
		offer_request(CMD_WRITE, '0);
		offer_request(CMD_NONE, 20'h5A5A5);
		offer_request(CMD_FLUSH, 20'hA5A5A);
		wait_idle();
	endtask

	task automatic test_page_limit();
		write_page_limit('0);
		offer_request(CMD_READ, 20'd1);
		offer_request(CMD_READ, '0);
		offer_request(CMD_WRITE, '1);
		wait_idle();
		write_page_limit('1);
	endtask

	// Fill every line, then miss twice: the first sweep passes over all lines
	task automatic test_full_sweep();
		for (int i = 1; i < NUM_LINES; i++)
			offer_request(CMD_WRITE, 20'hABC00 + PAGE_BITS'(i));
		offer_request(CMD_READ, 20'h01234);
		offer_request(CMD_WRITE, 20'hFEDCB);
		offer_request(CMD_FLUSH, '0);
		wait_idle();
	endtask

	// Output held off while requests keep coming, so the block backs up
	task automatic test_output_hold();
		hold_cycles <= 300;
		for (int i = 0; i < 12; i++)
			offer_request((i == 6) ? CMD_FLUSH : CMD_WRITE, PAGE_BITS'($urandom()));
		wait_idle();
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 8; i++)
			offer_request(CMD_WRITE, 20'h00100 + PAGE_BITS'(i));
		wait_idle();
		for (int i = 0; i < 8; i++)
			offer_request(CMD_READ, 20'h00100 + PAGE_BITS'(i));
		wait_idle();
	endtask

	// Random requests over a small set of hot pages, with noise around it
	task automatic test_random_traffic();
		logic [PAGE_BITS-1:0] limits [5];
		int                   counts [5];
		int                   done;
		int                   pick;
		logic [CMD_W-1:0]     cmd;
		logic [PAGE_BITS-1:0] page;
		limits = '{'1, PAGE_BITS'($urandom()), '0, PAGE_BITS'($urandom_range(8, 40)), '1};
		counts = '{65, 50, 20, 45, 60};
		for (int p = 0; p < 5; p++) begin
			write_page_limit(limits[p]);
			for (int h = 0; h < HOT_PAGES; h++)
				hot_pages[h] = ($urandom_range(0, 7) == 0) ? PAGE_BITS'($urandom())
					: PAGE_BITS'($urandom_range(0, page_limit));
			done = 0;
			while (done < counts[p]) begin
				pick = $urandom_range(0, 99);
				if (pick < 3)
					cmd = CMD_FLUSH;
				else if (pick < 6)
					cmd = CMD_NONE;
				else
					cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
				pick = $urandom_range(0, 9);
				if (pick < 8)
					page = hot_pages[$urandom_range(0, HOT_PAGES - 1)];
				else if (pick == 8)
					page = PAGE_BITS'($urandom());
				else
					page = PAGE_BITS'($urandom_range(page_limit, (1 << PAGE_BITS) - 1));
				offer_request(cmd, page);
				if (cmd != CMD_NONE)
					done++;
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_access();
		test_page_limit();
		test_full_sweep();
		test_output_hold();
		test_drain_pause();
		test_random_traffic();
		$display("%0d requests (%0d flushes, %0d evictions) and %0d result words checked,",
			requests_sent, flushes_sent, evictions_due, words_checked);
		$display("under page limits from zero to full range, with output hold-off and drains.");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
